// ===== hw/rtl/isp_pkg.sv =====
// Shared constants and types for the interpolating sample player.
// No dependencies; every other file in this block except isp_ram imports this package.

package isp_pkg;

  localparam int SAMPLE_DEPTH = 65536;
  localparam int SAMPLE_AW    = $clog2(SAMPLE_DEPTH);

  localparam int SMP_W     = 16;
  localparam int LEN_W     = 17;
  localparam int SPEED_W   = 20;
  localparam int AMP_W     = 15;
  localparam int START_W   = 16;
  localparam int FRAC_W    = 16;
  localparam int POS_W     = 34;
  localparam int SPAN_W    = LEN_W + FRAC_W;
  localparam int IDX_W     = POS_W - FRAC_W;
  localparam int OP_W      = 2;
  localparam int ADDR_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 20;

  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
  localparam logic [OP_W-1:0] OP_RETRIG  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR    = 3'd4;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [SPAN_W-1:0] span_t;

  // Handshake between the sequencer and the remainder unit.
  typedef struct packed {
    logic start;
    pos_t dividend;
    span_t divisor;
  } rem_req_t;

  typedef struct packed {
    logic  done;
    span_t rem;
  } rem_rsp_t;

endpackage

// ===== hw/rtl/isp_in_if.sv =====
// Request channel of the sample player: load, tick and retrigger requests.
// Depends on isp_pkg.

interface isp_in_if import isp_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [ADDR_W-1:0]        sample_address;
  logic signed [SMP_W-1:0]  sample_value;

  modport source (output valid, op, sample_address, sample_value, input ready);
  modport sink   (input valid, op, sample_address, sample_value, output ready);
endinterface

// ===== hw/rtl/isp_out_if.sv =====
// Result channel of the sample player: one audio sample per tick request.
// Depends on isp_pkg.

interface isp_out_if import isp_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] audio_out;

  modport source (output valid, audio_out, input ready);
  modport sink   (input valid, audio_out, output ready);
endinterface

// ===== hw/rtl/isp_cfg_if.sv =====
// Configuration write channel of the sample player: register index and data.
// Depends on isp_pkg.

interface isp_cfg_if import isp_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/isp_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.

module isp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/isp_rem.sv =====
// Bit-serial restoring remainder unit: position modulo the sample span.
// Depends on isp_pkg; one quotient bit is resolved per cycle.

module isp_rem import isp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  rem_req_t req,
  output rem_rsp_t rsp
);

  localparam int CNT_W = $clog2(POS_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  pos_t             x_r;
  span_t            r_r;
  logic [SPAN_W:0]  trial;
  logic             fits;
  span_t            r_nxt;

  // The caller must hold the divisor steady for the whole run; this unit does not enforce it.
  always_comb begin
    trial = {r_r, x_r[POS_W-1]};
    fits  = trial >= {1'b0, req.divisor};
    r_nxt = fits ? SPAN_W'(trial - {1'b0, req.divisor}) : trial[SPAN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(POS_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt_r <= '0;
      x_r   <= req.dividend;
      r_r   <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      x_r   <= {x_r[POS_W-2:0], 1'b0};
      r_r   <= r_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = r_r;

endmodule

// ===== hw/rtl/interpolating_sample_player.sv =====
// Linear interpolating sample player: sample RAM, tick sequencer, output register.
// Depends on isp_pkg, the three channel interfaces, isp_ram and isp_rem.
//
// Usage. Configuration writes arrive on cfg_ch (always ready); the user must
// make them while the player is idle, which the block does not enforce.
// Requests arrive on in_ch: a load writes one sample into the RAM, a retrigger
// moves the play position to length times start fraction, and a tick produces
// one result on out_ch. Loads and retriggers produce nothing.
// A tick occupies the sequencer for two RAM reads through the single read
// port, two multiplies and a rounding stage; its result then goes into the
// output register and the position is stepped. When the position has to be
// wrapped, the bit-serial remainder unit runs once for each wrap: once when
// the length was lowered below the position and once when a step runs past
// either end. With a length of zero a tick gives zero and leaves the position alone.
// in_ch is ready only while the sequencer is idle. A finished result waits
// in the output register; the next tick stalls before its result only while
// that register is still occupied. Reset clears the position and sets the
// configuration registers to their defaults; the sample RAM is not cleared
// and must be loaded before it is played.

module interpolating_sample_player import isp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  isp_in_if.sink  in_ch,
  isp_out_if.source out_ch,
  isp_cfg_if.sink cfg_ch
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_NORM = 4'd1;
  localparam logic [3:0] S_RD0  = 4'd2;
  localparam logic [3:0] S_RD1  = 4'd3;
  localparam logic [3:0] S_MUL1 = 4'd4;
  localparam logic [3:0] S_RND  = 4'd5;
  localparam logic [3:0] S_MUL2 = 4'd6;
  localparam logic [3:0] S_EMIT = 4'd7;
  localparam logic [3:0] S_ZERO = 4'd8;
  localparam logic [3:0] S_UPD  = 4'd9;
  localparam logic [3:0] S_WRAP = 4'd10;

  // Configuration registers.
  logic [LEN_W-1:0]   len_r;
  logic [SPEED_W-1:0] inc_r;
  logic [AMP_W-1:0]   amp_r;
  logic [START_W-1:0] start_r;
  logic               dir_r;

  logic [3:0] state_r, state_nxt;
  pos_t       pos_r, pos_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic signed [SMP_W-1:0] audio_r, audio_nxt;

  logic signed [SMP_W-1:0]     s0_r;
  logic signed [2*LEN_W-1:0]   prod1_r;
  logic signed [LEN_W-1:0]     interp_r;
  logic signed [LEN_W+AMP_W:0] prod2_r;
  logic                        rd_oob_r;

  logic in_acc;
  logic slot_free;
  span_t span;
  logic [LEN_W+START_W-1:0] retrig_pos;
  logic [IDX_W-1:0]  idx;
  logic [FRAC_W-1:0] frac;
  logic [IDX_W:0]    nidx_sum;
  logic [IDX_W-1:0]  nidx;
  logic [IDX_W-1:0]  rd_idx;
  logic [31:0]       rd_ext;
  logic [31:0]       wr_ext;
  logic              ram_we;
  logic [SMP_W-1:0]  ram_rdata;
  logic signed [SMP_W-1:0]     smp;
  logic signed [LEN_W-1:0]     diff;
  logic signed [LEN_W-1:0]     frac_s;
  logic signed [POS_W:0]       interp_sum;
  logic signed [AMP_W:0]       amp_s;
  logic signed [LEN_W+AMP_W:0] y_sum;
  logic signed [LEN_W+1:0]     y_wide;
  logic signed [SMP_W-1:0]     y_sat;
  pos_t                        fwd_sum;
  logic [SPEED_W-1:0]          back_gap;
  rem_req_t rem_req;
  rem_rsp_t rem_rsp;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;

  assign span       = {len_r, FRAC_W'(0)};
  assign retrig_pos = len_r * start_r;
  assign idx        = pos_r[POS_W-1:FRAC_W];
  assign frac       = pos_r[FRAC_W-1:0];
  assign nidx_sum   = {1'b0, idx} + 1'b1;
  assign nidx       = (nidx_sum >= (IDX_W+1)'(len_r)) ? '0 : nidx_sum[IDX_W-1:0];

  // RAM access: the first read fetches sample i, the second its neighbour.
  assign rd_idx = (state_r == S_RD1) ? nidx : idx;
  assign rd_ext = 32'(rd_idx);
  assign wr_ext = 32'(in_ch.sample_address);
  assign ram_we = in_acc && in_ch.op == OP_LOAD && wr_ext < 32'(SAMPLE_DEPTH);

  isp_ram #(
    .WIDTH (SMP_W),
    .DEPTH (SAMPLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ext[SAMPLE_AW-1:0]),
    .wdata (in_ch.sample_value),
    .raddr (rd_ext[SAMPLE_AW-1:0]),
    .rdata (ram_rdata)
  );

  isp_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  always_ff @(posedge clk) begin
    rd_oob_r <= rd_ext >= 32'(SAMPLE_DEPTH);
  end

  // Arithmetic datapath; each multiply is registered before the next step.
  always_comb begin
    smp        = rd_oob_r ? '0 : $signed(ram_rdata);
    diff       = LEN_W'(smp) - LEN_W'(s0_r);
    frac_s     = $signed({1'b0, frac});
    interp_sum = ((POS_W+1)'(s0_r) <<< FRAC_W) + (POS_W+1)'(prod1_r)
                 + (POS_W+1)'(32768);
    amp_s      = $signed({1'b0, amp_r});
    y_sum      = prod2_r + (LEN_W+AMP_W+1)'(8192);
    y_wide     = y_sum[LEN_W+AMP_W:14];
    if (y_wide > (LEN_W+2)'(32767)) begin
      y_sat = 16'sh7FFF;
    end else if (y_wide < -(LEN_W+2)'(32768)) begin
      y_sat = -16'sh8000;
    end else begin
      y_sat = y_wide[SMP_W-1:0];
    end
    fwd_sum  = pos_r + POS_W'(inc_r);
    back_gap = inc_r - pos_r[SPEED_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RD1) begin
      s0_r <= smp;
    end
    if (state_r == S_MUL1) begin
      prod1_r <= diff * frac_s;
    end
    if (state_r == S_RND) begin
      interp_r <= interp_sum[FRAC_W+LEN_W-1:FRAC_W];
    end
    if (state_r == S_MUL2) begin
      prod2_r <= interp_r * amp_s;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    pos_nxt          = pos_r;
    out_valid_nxt    = out_valid_r;
    audio_nxt        = audio_r;
    rem_req.start    = 1'b0;
    rem_req.dividend = pos_r;
    rem_req.divisor  = span;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.op == OP_RETRIG) begin
            pos_nxt = POS_W'(retrig_pos);
          end else if (in_ch.op == OP_TICK) begin
            if (len_r == '0) begin
              state_nxt = S_ZERO;
            end else if ({1'b0, pos_r} >= {2'b00, span}) begin
              // The length was lowered below the position: wrap it first.
              rem_req.start = 1'b1;
              state_nxt     = S_NORM;
            end else begin
              state_nxt = S_RD0;
            end
          end
        end
      end
      S_NORM: begin
        if (rem_rsp.done) begin
          pos_nxt   = POS_W'(rem_rsp.rem);
          state_nxt = S_RD0;
        end
      end
      S_RD0:  state_nxt = S_RD1;
      S_RD1:  state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_RND;
      S_RND:  state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_EMIT;
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          audio_nxt     = y_sat;
          state_nxt     = S_UPD;
        end
      end
      S_ZERO: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          audio_nxt     = '0;
          state_nxt     = S_IDLE;
        end
      end
      S_UPD: begin
        if (!dir_r) begin
          if (fwd_sum >= POS_W'(span)) begin
            rem_req.start    = 1'b1;
            rem_req.dividend = fwd_sum;
            state_nxt        = S_WRAP;
          end else begin
            pos_nxt   = fwd_sum;
            state_nxt = S_IDLE;
          end
        end else if (POS_W'(inc_r) <= pos_r) begin
          pos_nxt   = pos_r - POS_W'(inc_r);
          state_nxt = S_IDLE;
        end else begin
          // Stepping below zero: wrap the overshoot back from the top end.
          rem_req.start    = 1'b1;
          rem_req.dividend = POS_W'(back_gap);
          state_nxt        = S_WRAP;
        end
      end
      S_WRAP: begin
        if (rem_rsp.done) begin
          if (!dir_r) begin
            pos_nxt = POS_W'(rem_rsp.rem);
          end else if (rem_rsp.rem == '0) begin
            pos_nxt = '0;
          end else begin
            pos_nxt = POS_W'(span - rem_rsp.rem);
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    audio_r <= audio_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      inc_r   <= SPEED_W'(65536);
      amp_r   <= AMP_W'(16384);
      start_r <= '0;
      dir_r   <= 1'b0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_LENGTH: len_r   <= cfg_ch.data[LEN_W-1:0];
        REG_SPEED:  inc_r   <= cfg_ch.data[SPEED_W-1:0];
        REG_AMP:    amp_r   <= cfg_ch.data[AMP_W-1:0];
        REG_START:  start_r <= cfg_ch.data[START_W-1:0];
        REG_DIR:    dir_r   <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready    = 1'b1;
  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.audio_out = audio_r;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the interpolating sample player.
// Depends on isp_pkg, isp_in_if, isp_out_if, isp_cfg_if and the player itself;
// predicts every audio sample and compares it with what the block returns.

module tb;
  import isp_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  // One tick plus two passes of the remainder unit, with margin.
  localparam int DRAIN_CYCLES = 90;
  localparam int HOLD_CYCLES  = 400;
  // Random lengths stay within the entries written at the start.
  localparam int FILL_COUNT   = 32;

  logic clk;
  logic rst_n;

  isp_in_if  in_ch ();
  isp_out_if out_ch ();
  isp_cfg_if cfg_ch ();

  interpolating_sample_player uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Predicted state of the player.
  logic signed [SMP_W-1:0] wave_mem [0:SAMPLE_DEPTH-1];
  longint play_pos;
  longint len_reg;
  longint speed_reg;
  longint amp_reg;
  longint start_reg;
  logic   dir_reg;

  logic signed [SMP_W-1:0] expected_audio [$];
  int fault_count;
  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_start;
  bit hold_active;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Interpolates at the current position, then steps and wraps the position.
  function automatic logic signed [SMP_W-1:0] next_audio();
    longint span, idx, nidx, frac, s0, s1, v, y, d;
    if (len_reg == 0) return '0;
    span = len_reg << 16;
    if (play_pos >= span) play_pos = play_pos % span;
    idx  = play_pos >> 16;
    frac = play_pos & 64'hFFFF;
    nidx = idx + 1;
    if (nidx >= len_reg) nidx = 0;
    s0 = wave_mem[idx];
    s1 = wave_mem[nidx];
    v = s0 * 65536 + (s1 - s0) * frac;
    v = (v + 32768) >>> 16;
    y = (v * amp_reg + 8192) >>> 14;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    if (!dir_reg) begin
      play_pos = play_pos + speed_reg;
      if (play_pos >= span) play_pos = play_pos % span;
    end else if (speed_reg <= play_pos) begin
      play_pos = play_pos - speed_reg;
    end else begin
      d = (speed_reg - play_pos) % span;
      play_pos = (d == 0) ? 0 : span - d;
    end
    return y[SMP_W-1:0];
  endfunction

  // Receiver: random stalls, or a long hold-off while hold_active is set.
  always @(negedge clk) begin
    out_ch.ready = !hold_active && ($urandom_range(99) >= rx_idle_pct);
  end

  initial forever begin
    wait (hold_start);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active = 1'b0;
    hold_start  = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_audio.size() == 0) begin
        if (fault_count < 10)
          $display("%0t: audio_out %0d arrived with no tick outstanding", $realtime,
                   out_ch.audio_out);
        fault_count++;
      end else begin
        if (out_ch.audio_out !== expected_audio[0]) begin
          if (fault_count < 10)
            $display("%0t: audio_out mismatch, expected %0d, got %0d", $realtime,
                     expected_audio[0], out_ch.audio_out);
          fault_count++;
        end
        void'(expected_audio.pop_front());
      end
    end
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                              input logic signed [SMP_W-1:0] value);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid          = 1'b1;
    in_ch.op             = op;
    in_ch.sample_address = addr;
    in_ch.sample_value   = value;
    do @(posedge clk); while (!in_ch.ready);
    case (op)
      OP_LOAD:   wave_mem[addr] = value;
      OP_TICK:   expected_audio.push_back(next_audio());
      OP_RETRIG: play_pos = len_reg * start_reg;
      default: ;
    endcase
  endtask

  task automatic send_tick();
    send_request(OP_TICK, ADDR_W'($urandom), SMP_W'($urandom));
  endtask

  // Stops the request stream and waits until the player has gone quiet.
  task automatic settle_player();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_audio.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_LENGTH: len_reg   = data & 20'h1FFFF;
      REG_SPEED:  speed_reg = data;
      REG_AMP:    amp_reg   = data & 20'h07FFF;
      REG_START:  start_reg = data & 20'h0FFFF;
      REG_DIR:    dir_reg   = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic randomise_settings();
    int pick;
    pick = $urandom_range(9);
    case (pick)
      0: write_register(REG_LENGTH, 0);
      1: write_register(REG_LENGTH, 1);
      2: write_register(REG_LENGTH, CFG_DAT_W'(FILL_COUNT));
      3: write_register(REG_LENGTH, CFG_DAT_W'($urandom_range(0, FILL_COUNT)));
      default: write_register(REG_LENGTH, CFG_DAT_W'($urandom_range(2, FILL_COUNT)));
    endcase
    pick = $urandom_range(9);
    case (pick)
      0: write_register(REG_SPEED, 0);
      1: write_register(REG_SPEED, 1048575);
      2: write_register(REG_SPEED, 65536);
      3, 4: write_register(REG_SPEED, CFG_DAT_W'($urandom_range(0, 1048575)));
      default: write_register(REG_SPEED, CFG_DAT_W'($urandom_range(0, 131071)));
    endcase
    pick = $urandom_range(5);
    case (pick)
      0: write_register(REG_AMP, 0);
      1: write_register(REG_AMP, 32767);
      2: write_register(REG_AMP, 16384);
      default: write_register(REG_AMP, CFG_DAT_W'($urandom_range(0, 32767)));
    endcase
    pick = $urandom_range(4);
    case (pick)
      0: write_register(REG_START, 0);
      1: write_register(REG_START, 65535);
      default: write_register(REG_START, CFG_DAT_W'($urandom_range(0, 65535)));
    endcase
    write_register(REG_DIR, CFG_DAT_W'($urandom_range(1)));
  endtask

  // Ticks at reset, with nothing loaded, must give silence.
  task automatic test_empty_sample();
    send_tick();
    send_request(OP_RETRIG, '0, '0);
    send_tick();
    send_request(OP_SPARE, '1, '1);
    settle_player();
  endtask

  // The low entries and the top one are written, so that every position
  // reached later reads a loaded sample.
  task automatic test_fill_memory();
    for (int a = 0; a < FILL_COUNT; a++)
      send_request(OP_LOAD, a[ADDR_W-1:0], SMP_W'($urandom));
    send_request(OP_LOAD, ADDR_W'(SAMPLE_DEPTH - 1), SMP_W'($urandom));
    settle_player();
  endtask

  task automatic test_directed_playback();
    send_request(OP_LOAD, 16'd0, 16'sh7FFF);
    send_request(OP_LOAD, 16'd1, -16'sd32768);
    send_request(OP_LOAD, 16'd2, 16'sd0);
    send_request(OP_LOAD, 16'd3, -16'sd1);
    settle_player();
    write_register(REG_LENGTH, 4);
    write_register(REG_SPEED, 20'h08000);
    write_register(REG_AMP, 32767);
    write_register(REG_START, 0);
    write_register(REG_DIR, 0);
    // Half steps cover both extremes, saturation and the wrap from the last sample.
    send_request(OP_RETRIG, '0, '0);
    repeat (8) send_tick();
    settle_player();
    write_register(REG_DIR, 1);
    write_register(REG_SPEED, 1048575);
    repeat (3) send_tick();
    settle_player();
    write_register(REG_LENGTH, 1);
    write_register(REG_DIR, 0);
    repeat (2) send_tick();
    settle_player();
    write_register(REG_AMP, 0);
    send_tick();
    settle_player();
    // Full length from the last entry, then a shorter length leaves the position stale.
    write_register(REG_LENGTH, 65536);
    write_register(REG_SPEED, 0);
    write_register(REG_START, 65535);
    write_register(REG_AMP, 16384);
    send_request(OP_RETRIG, '0, '0);
    send_tick();
    settle_player();
    write_register(REG_LENGTH, 3);
    send_tick();
    send_request(OP_SPARE, 16'hFFFF, 16'sh7FFF);
    settle_player();
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_items);
    int sent;
    int burst;
    int pick;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      settle_player();
      randomise_settings();
      burst = $urandom_range(10, 40);
      repeat (burst) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          send_tick();
        end else if (pick < 80) begin
          if (len_reg > 0 && $urandom_range(1))
            send_request(OP_LOAD, ADDR_W'($urandom_range(0, 32'(len_reg - 1))),
                         SMP_W'($urandom));
          else
            send_request(OP_LOAD, ADDR_W'($urandom), SMP_W'($urandom));
        end else if (pick < 93) begin
          send_request(OP_RETRIG, ADDR_W'($urandom), SMP_W'($urandom));
        end else begin
          send_request(OP_SPARE, ADDR_W'($urandom), SMP_W'($urandom));
        end
      end
      sent += burst;
    end
    settle_player();
  endtask

  // The receiver holds off long enough for the output register and the
  // sequencer to fill, so the request channel has to stall.
  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_register(REG_LENGTH, 8);
    write_register(REG_SPEED, CFG_DAT_W'($urandom_range(0, 262143)));
    write_register(REG_DIR, 0);
    @(posedge clk);
    hold_start = 1'b1;
    repeat (30) send_tick();
    settle_player();
  endtask

  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.op             = OP_LOAD;
    in_ch.sample_address = '0;
    in_ch.sample_value   = '0;
    out_ch.ready         = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = REG_LENGTH;
    cfg_ch.data          = '0;
    fault_count          = 0;
    tx_idle_pct          = 0;
    rx_idle_pct          = 0;
    play_pos             = 0;
    len_reg              = 0;
    speed_reg            = 65536;
    amp_reg              = 16384;
    start_reg            = 0;
    dir_reg              = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_sample();
    test_fill_memory();
    test_directed_playback();
    test_random_traffic(24, 76, 150);
    test_random_traffic(76, 24, 150);
    test_random_traffic(0, 0, 140);
    test_output_backpressure();

    if (fault_count == 0 && expected_audio.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
